>>> design/crpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crpp_pkg;

    // Only the first ten bytes of a packet feed any result field.
    localparam int NUM_KEPT = 10;
    localparam logic [7:0] TERMINATOR = 8'hFF;
    localparam logic [7:0] NIBBLE_HI_MASK = 8'hF0;
    localparam logic [7:0] CLASS_ACK = 8'h40;
    localparam logic [7:0] CLASS_COMPLETION = 8'h50;
    localparam logic [7:0] CLASS_ERROR = 8'h60;
    localparam logic [7:0] INQUIRY_CODE = 8'h50;
    localparam logic [7:0] POWER_ON_CODE = 8'h02;
    localparam logic [3:0] ADDRESS_OFFSET = 4'h8;

    typedef enum logic [2:0] {
        KIND_ACK        = 3'd0,
        KIND_COMPLETION = 3'd1,
        KIND_INQUIRY    = 3'd2,
        KIND_ERROR      = 3'd3,
        KIND_UNKNOWN    = 3'd4,
        KIND_OVERFLOW   = 3'd5
    } kind_t;

    typedef logic [NUM_KEPT-1:0][7:0] window_t;

    // Packet view handed from the buffer to the decoder.
    typedef struct packed {
        window_t     bytes;
        logic        is_term;
        logic        last_slot;
        logic [4:0]  length;
    } view_t;

    typedef struct packed {
        logic [4:0]         packet_length;
        logic signed [15:0] second_value;
        logic signed [15:0] first_value;
        logic               power_on;
        logic [7:0]         status_byte;
        logic signed [3:0]  sender_address;
        kind_t              reply_kind;
    } reply_t;

endpackage

`default_nettype wire

>>> design/camera_reply_packet_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tdata[55:0] reply fields, one word per finished packet
//
// Each byte passes an input register, then the buffer and decoder logic,
// then the result register: one byte per clock unless a held result stalls it, and the
// result word becomes valid as the byte that finishes the packet leaves the input register.
// A stalled result blocks a byte only if that byte would itself make a result.
// Reset clears the byte count and both valid flags; the buffer is masked by the count.

module camera_reply_packet_parser #(
    parameter int MAX_PACKET = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata    // [2:0] reply_kind, [6:3] sender_address,
                                         // [14:7] status_byte, [15] power_on,
                                         // [31:16] first_value, [47:32] second_value,
                                         // [52:48] packet_length, [55:53] zero
);
    import crpp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    reply_t     out_reply_reg;
    view_t      view;
    logic       emit;
    reply_t     reply;
    logic       out_free;
    logic       fire;

    crpp_packet_buffer #(
        .MAX_PACKET (MAX_PACKET)
    ) u_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .rx_byte (in_byte_reg),
        .view    (view)
    );

    crpp_reply_decoder u_decoder (
        .view  (view),
        .emit  (emit),
        .reply (reply)
    );

    // A byte moves on unless it makes a result and the result slot is held.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && fire && emit)
            out_reply_reg <= reply;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reply_reg};

endmodule

`default_nettype wire

>>> design/crpp_packet_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

module crpp_packet_buffer #(
    parameter int MAX_PACKET = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic [7:0]    rx_byte,
    output crpp_pkg::view_t    view
);
    import crpp_pkg::*;

    localparam int CNT_W = $clog2(MAX_PACKET + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] len;
    logic [7:0]       store_reg [NUM_KEPT];

    assign len = count_reg + CNT_W'(1);

    // Bytes past the fill point read as zero; the current byte sits at the fill point.
    always_comb
    begin
        for (int i = 0; i < NUM_KEPT; i++)
        begin
            if (CNT_W'(i) < count_reg)
                view.bytes[i] = store_reg[i];
            else if (CNT_W'(i) == count_reg)
                view.bytes[i] = rx_byte;
            else
                view.bytes[i] = 8'h00;
        end
        view.is_term   = (rx_byte == TERMINATOR);
        view.last_slot = (len == CNT_W'(MAX_PACKET));
        view.length    = 5'(len);
    end

    // A finished or overflowed packet restarts the fill point.
    always_comb
    begin
        if (view.is_term || view.last_slot)
            count_next = '0;
        else
            count_next = len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (advance)
            count_reg <= count_next;
    end

    // Packet storage needs no reset: unfilled slots are masked by the count.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_KEPT; i++)
        begin
            if (advance && (count_reg == CNT_W'(i)))
                store_reg[i] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> design/crpp_reply_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

module crpp_reply_decoder (
    input  wire crpp_pkg::view_t  view,
    output logic                  emit,
    output crpp_pkg::reply_t      reply
);
    import crpp_pkg::*;

    logic [7:0] b1;

    assign b1   = view.bytes[1];
    assign emit = view.is_term || view.last_slot;

    always_comb
    begin
        reply = '0;
        reply.packet_length = view.length;
        if (view.is_term)
        begin
            // Classify from the upper nibble of byte 1.
            priority if ((b1 & NIBBLE_HI_MASK) == CLASS_ACK)
                reply.reply_kind = KIND_ACK;
            else if ((b1 & NIBBLE_HI_MASK) == CLASS_COMPLETION)
                reply.reply_kind = (b1 == INQUIRY_CODE) ? KIND_INQUIRY : KIND_COMPLETION;
            else if ((b1 & NIBBLE_HI_MASK) == CLASS_ERROR)
                reply.reply_kind = KIND_ERROR;
            else
                reply.reply_kind = KIND_UNKNOWN;

            reply.sender_address = view.bytes[0][7:4] ^ ADDRESS_OFFSET;
            reply.status_byte    = view.bytes[2];
            reply.power_on       = (view.bytes[2] == POWER_ON_CODE);
            // Each half is the low byte of (first << 4) | second, an OR and not a join.
            reply.first_value    = {({view.bytes[2][3:0], 4'h0} | view.bytes[3]),
                                    ({view.bytes[4][3:0], 4'h0} | view.bytes[5])};
            reply.second_value   = {({view.bytes[6][3:0], 4'h0} | view.bytes[7]),
                                    ({view.bytes[8][3:0], 4'h0} | view.bytes[9])};
        end
        else
        begin
            reply.reply_kind = KIND_OVERFLOW;
        end
    end

endmodule

`default_nettype wire

>>> bench/camera_reply_packet_parser_test.sv
`timescale 1ns / 1ps

module camera_reply_packet_parser_test;
    import crpp_pkg::*;

    localparam int MAX_PACKET = 16;
    localparam int RANDOM_BYTES = 1000;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PERCENT = 23;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    logic [7:0]  byte_queue[$];
    reply_t      expected_replies[$];

    // Shadow of the packet buffer.
    logic [7:0]  shadow_bytes[MAX_PACKET];
    int unsigned shadow_count;

    int          mismatch_count;
    int          bytes_taken;
    int          quiet_cycles;
    bit          rx_taken;

    camera_reply_packet_parser #(
        .MAX_PACKET(MAX_PACKET)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    // No idling while the middle of the run goes by.
    function automatic bit take_break();
        if (bytes_taken >= 300 && bytes_taken < 500)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    function automatic logic [15:0] join_nibbles(int first);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = (shadow_bytes[first] << 4) | shadow_bytes[first + 1];
        lo = (shadow_bytes[first + 2] << 4) | shadow_bytes[first + 3];
        return {hi, lo};
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < MAX_PACKET; i++)
            shadow_bytes[i] = 8'h00;
        shadow_count = 0;
    endfunction

    // Track one received byte and queue the reply it finishes, if any.
    function automatic void parse_rx_byte(logic [7:0] rx);
        reply_t     reply;
        logic [7:0] class_bits;
        if (shadow_count < MAX_PACKET)
            shadow_bytes[shadow_count] = rx;
        shadow_count++;
        reply = '0;
        if (rx != TERMINATOR) begin
            if (shadow_count >= MAX_PACKET) begin
                reply.reply_kind = KIND_OVERFLOW;
                reply.packet_length = shadow_count[4:0];
                expected_replies.push_back(reply);
                clear_shadow();
            end
        end
        else begin
            class_bits = shadow_bytes[1] & NIBBLE_HI_MASK;
            if (class_bits == CLASS_ACK)
                reply.reply_kind = KIND_ACK;
            else if (class_bits == CLASS_COMPLETION)
                reply.reply_kind = (shadow_bytes[1] == INQUIRY_CODE) ? KIND_INQUIRY
                                                                     : KIND_COMPLETION;
            else if (class_bits == CLASS_ERROR)
                reply.reply_kind = KIND_ERROR;
            else
                reply.reply_kind = KIND_UNKNOWN;
            reply.sender_address = shadow_bytes[0][7:4] ^ ADDRESS_OFFSET;
            reply.status_byte = shadow_bytes[2];
            reply.power_on = (shadow_bytes[2] == POWER_ON_CODE);
            reply.first_value = join_nibbles(2);
            reply.second_value = join_nibbles(6);
            reply.packet_length = shadow_count[4:0];
            expected_replies.push_back(reply);
            clear_shadow();
        end
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    function automatic logic [7:0] any_but_terminator();
        return 8'($urandom_range(0, 254));
    endfunction

    // Payload bytes are mostly nibbles, sometimes any non-terminator byte.
    function automatic logic [7:0] payload_byte();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 15));
        return any_but_terminator();
    endfunction

    function automatic logic [7:0] class_byte();
        case ($urandom_range(0, 5))
            0: return CLASS_ACK | 8'($urandom_range(0, 15));
            1: return INQUIRY_CODE;
            2: return CLASS_COMPLETION | 8'($urandom_range(0, 15));
            3: return CLASS_ERROR | 8'($urandom_range(0, 15));
            default: return any_but_terminator();
        endcase
    endfunction

    // Queue one terminated packet of the given length before the terminator.
    task automatic queue_packet(int body);
        for (int i = 0; i < body; i++) begin
            if (i == 0)
                byte_queue.push_back($urandom_range(0, 9) < 8 ?
                                     {4'($urandom_range(8, 15)), 4'($urandom_range(0, 15))}
                                     : any_but_terminator());
            else if (i == 1)
                byte_queue.push_back(class_byte());
            else
                byte_queue.push_back(payload_byte());
        end
        byte_queue.push_back(TERMINATOR);
    endtask

    // Input driver: presents the next byte once the previous one was taken.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || rx_taken) begin
                if (byte_queue.size() > 0 && !take_break()) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= byte_queue.pop_front();
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !take_break();
        end
        rx_taken = 1'b0;
    end

    // Input side: feed every accepted byte to the predictor.
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            parse_rx_byte(s_tdata);
            bytes_taken++;
            rx_taken = 1'b1;
        end
    end

    // Output monitor: compare each accepted word with the oldest expected reply.
    always @(posedge clk) begin
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata[52:0];
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected reply word", m_tdata, 0);
            end
            else begin
                want = expected_replies.pop_front();
                if (got.reply_kind != want.reply_kind)
                    report_mismatch("reply_kind", got.reply_kind, want.reply_kind);
                if (got.sender_address != want.sender_address)
                    report_mismatch("sender_address", got.sender_address,
                                    want.sender_address);
                if (got.status_byte != want.status_byte)
                    report_mismatch("status_byte", got.status_byte, want.status_byte);
                if (got.power_on != want.power_on)
                    report_mismatch("power_on", got.power_on, want.power_on);
                if (got.first_value != want.first_value)
                    report_mismatch("first_value", got.first_value, want.first_value);
                if (got.second_value != want.second_value)
                    report_mismatch("second_value", got.second_value, want.second_value);
                if (got.packet_length != want.packet_length)
                    report_mismatch("packet_length", got.packet_length,
                                    want.packet_length);
                if (m_tdata[55:53] != 3'b000)
                    report_mismatch("pad bits", m_tdata[55:53], 0);
            end
        end
    end

    // Watchdog on cycles without any word moving on either side.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int pick;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        m_tready = 1'b0;
        mismatch_count = 0;
        bytes_taken = 0;
        rx_taken = 1'b0;
        clear_shadow();

        // Directed packets: a lone terminator, then ack, inquiry, completion
        // with power on, error, unknown class and a short packet with low
        // sender nibble.
        byte_queue = '{8'hFF,
                       8'h90, 8'h41, 8'hFF,
                       8'hA0, 8'h50, 8'hFF,
                       8'hF1, 8'h51, 8'h02, 8'hFF,
                       8'h8F, 8'h6F, 8'h03, 8'hFF,
                       8'h00, 8'h30, 8'hFE, 8'hFF,
                       8'h7F, 8'h00, 8'hFF};

        // Random part: mostly well-formed packets, some overflow runs and noise.
        while (byte_queue.size() < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat (MAX_PACKET + $urandom_range(0, 1) * $urandom_range(1, 4))
                    byte_queue.push_back(any_but_terminator());
            end
            else if (pick < 14) begin
                repeat ($urandom_range(1, 5))
                    byte_queue.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick < 24) begin
                queue_packet(MAX_PACKET - 1);
            end
            else begin
                queue_packet($urandom_range(0, 1) ? $urandom_range(9, MAX_PACKET - 2)
                                                  : $urandom_range(0, 8));
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_queue.size() > 0 || s_tvalid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
